// ===== hw/rtl/gff_pkg.sv =====
// Shared types, codes and constants for the grid flood fill block.
`default_nettype none

package gff_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int ACTION_W = 2;
  localparam int COORD_W  = 6;
  localparam int CELL_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CELL_W-1:0] OPEN_CELL   = 8'd46;
  localparam logic [CELL_W-1:0] FILLED_CELL = 8'd88;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FILLED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SEED,
    ST_POP,
    ST_LOAD,
    ST_NB_RD,
    ST_NB_CHK
  } fsm_t;

  typedef struct packed {
    logic we;
    logic re;
  } grid_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gff_grid.sv =====
// Cell grid memory with a clearing sweep after reset.
`default_nettype none

module gff_grid #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire gff_pkg::grid_ctl_t        ctl,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [gff_pkg::CELL_W-1:0] wdata,
  output logic      [gff_pkg::CELL_W-1:0] rdata,
  output logic                           busy
);
  import gff_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= OPEN_CELL;
    end else if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gff_stack.sv =====
// Pending cell stack: memory plus depth counter.
`default_nettype none

module gff_stack #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int SW    = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gff_pkg::stack_ctl_t  ctl,
  input  wire logic [SW-1:0]        wdata,
  output logic      [SW-1:0]        rdata,
  output logic                      empty
);
  import gff_pkg::*;

  logic [SW-1:0] mem [DEPTH];
  logic [AW:0]   depth;
  logic [AW:0]   depth_m1;

  assign depth_m1 = depth - 1'b1;
  assign empty    = (depth == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (ctl.push) begin
      depth <= depth + 1'b1;
    end else if (ctl.pop) begin
      depth <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[depth[AW-1:0]] <= wdata;
    end
    if (ctl.pop) begin
      rdata <= mem[depth_m1[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_flood_fill.sv =====
// Top level of the grid flood fill block: sequencer, registers and result stage.
`default_nettype none

// Grid of MAX_ROWS x MAX_COLS byte cells with write, read and four-connected fill
// items. After reset the grid memory is swept to open cells, one cell per cycle;
// items are stalled during the sweep, while register writes are taken. A write
// and a rejected or unused item load their result when taken; a read waits for
// the registered grid read. A fill first checks the seed, then for each filled
// cell pops the stack, skips edge neighbors and reads and checks the others in
// turn, and finishes when the stack is empty; the grid memory is single-port, so
// each read/modify/write goes in steps. Items are stalled until the fill is done.
// One result per item; a finished result waits in an output register, and the next
// item is taken only while that register is free or being read out.
module grid_flood_fill #(
  parameter int MAX_ROWS = gff_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gff_pkg::DEF_MAX_COLS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gff_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [gff_pkg::PDATA_W-1:0]     pwdata,
  output logic      [gff_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic [gff_pkg::ACTION_W-1:0]    action,
  input  wire logic [gff_pkg::COORD_W-1:0]     cell_row,
  input  wire logic [gff_pkg::COORD_W-1:0]     cell_col,
  input  wire logic [gff_pkg::CELL_W-1:0]      cell_value,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic      [gff_pkg::CELL_W-1:0]      read_value,
  output logic      [gff_pkg::STATUS_W-1:0]    status
);
  import gff_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW    = RW + CW;

  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [RW:0]      rows_eff;
  logic [CW:0]      cols_eff;

  fsm_t state;
  fsm_t state_next;

  grid_ctl_t  grid_ctl;
  stack_ctl_t stack_ctl;
  logic [AW-1:0]     grid_addr;
  logic [CELL_W-1:0] grid_wdata;
  logic [CELL_W-1:0] grid_rdata;
  logic              grid_busy;
  logic [SW-1:0]     stack_wdata;
  logic [SW-1:0]     stack_rdata;
  logic              stack_empty;

  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic [1:0]    nb;
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  logic          nb_ok;
  logic [RW-1:0] in_r;
  logic [CW-1:0] in_c;
  logic          in_range;
  logic [RW-1:0] a_r;
  logic [CW-1:0] a_c;

  logic              out_free;
  logic              out_load;
  logic [CELL_W-1:0] out_value;
  logic [STATUS_W-1:0] out_status;
  logic              cur_ld_in;
  logic              cur_ld_stk;
  logic              nb_clr;
  logic              nb_inc;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= CFG_W'(64);
      cols_cfg <= CFG_W'(64);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ROWS: rows_cfg <= pwdata[CFG_W-1:0];
        REG_COLS: cols_cfg <= pwdata[CFG_W-1:0];
        default:  rows_cfg <= rows_cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = PDATA_W'(rows_cfg);
      REG_COLS: prdata = PDATA_W'(cols_cfg);
      default:  prdata = '0;
    endcase
  end

  assign rows_eff = (RW+1)'(clamp_size(rows_cfg, MAX_ROWS));
  assign cols_eff = (CW+1)'(clamp_size(cols_cfg, MAX_COLS));

  assign in_range = (int'(cell_row) < int'(rows_eff)) && (int'(cell_col) < int'(cols_eff));
  assign in_r     = RW'(cell_row);
  assign in_c     = CW'(cell_col);

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (nb)
      2'd0: begin
        nb_r  = cur_r - 1'b1;
        nb_ok = (cur_r != '0);
      end
      2'd1: begin
        nb_r  = cur_r + 1'b1;
        nb_ok = ((RW+1)'(cur_r) + 1'b1) < rows_eff;
      end
      2'd2: begin
        nb_c  = cur_c + 1'b1;
        nb_ok = ((CW+1)'(cur_c) + 1'b1) < cols_eff;
      end
      default: begin
        nb_c  = cur_c - 1'b1;
        nb_ok = (cur_c != '0);
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        a_r = in_r;
        a_c = in_c;
      end
      ST_SEED: begin
        a_r = cur_r;
        a_c = cur_c;
      end
      default: begin
        a_r = nb_r;
        a_c = nb_c;
      end
    endcase
  end

  assign grid_addr = AW'(int'(a_r) * MAX_COLS + int'(a_c));
  assign grid_wdata = (state == ST_IDLE) ? cell_value : FILLED_CELL;
  assign stack_wdata = (state == ST_SEED) ? {cur_r, cur_c} : {nb_r, nb_c};

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == ST_IDLE) && out_free);

  always_comb begin
    state_next = state;
    grid_ctl   = '0;
    stack_ctl  = '0;
    out_load   = 1'b0;
    out_value  = '0;
    out_status = STAT_OK;
    cur_ld_in  = 1'b0;
    cur_ld_stk = 1'b0;
    nb_clr     = 1'b0;
    nb_inc     = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (!grid_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid && out_free) begin
          cur_ld_in = 1'b1;
          if (action == ACT_NONE) begin
            out_load = 1'b1;
          end else if (!in_range) begin
            out_load   = 1'b1;
            out_status = STAT_RANGE;
          end else begin
            case (action)
              ACT_WRITE: begin
                grid_ctl.we = 1'b1;
                out_load    = 1'b1;
              end
              ACT_READ: begin
                grid_ctl.re = 1'b1;
                state_next  = ST_READ;
              end
              default: begin
                grid_ctl.re = 1'b1;
                state_next  = ST_SEED;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        out_load   = 1'b1;
        out_value  = grid_rdata;
        state_next = ST_IDLE;
      end
      ST_SEED: begin
        if (grid_rdata == FILLED_CELL) begin
          out_load   = 1'b1;
          out_status = STAT_FILLED;
          state_next = ST_IDLE;
        end else begin
          grid_ctl.we    = 1'b1;
          stack_ctl.push = 1'b1;
          state_next     = ST_POP;
        end
      end
      ST_POP: begin
        if (stack_empty) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          stack_ctl.pop = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cur_ld_stk = 1'b1;
        nb_clr     = 1'b1;
        state_next = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (nb_ok) begin
          grid_ctl.re = 1'b1;
          state_next  = ST_NB_CHK;
        end else if (nb == 2'd3) begin
          state_next = ST_POP;
        end else begin
          nb_inc = 1'b1;
        end
      end
      ST_NB_CHK: begin
        if (grid_rdata == OPEN_CELL) begin
          grid_ctl.we    = 1'b1;
          stack_ctl.push = 1'b1;
        end
        if (nb == 2'd3) begin
          state_next = ST_POP;
        end else begin
          nb_inc     = 1'b1;
          state_next = ST_NB_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_ld_in) begin
      cur_r <= in_r;
      cur_c <= in_c;
    end else if (cur_ld_stk) begin
      cur_r <= stack_rdata[SW-1:CW];
      cur_c <= stack_rdata[CW-1:0];
    end
    if (nb_clr) begin
      nb <= 2'd0;
    end else if (nb_inc) begin
      nb <= nb + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value <= out_value;
      status     <= out_status;
    end
  end

  gff_grid #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .rst   (rst),
    .ctl   (grid_ctl),
    .addr  (grid_addr),
    .wdata (grid_wdata),
    .rdata (grid_rdata),
    .busy  (grid_busy)
  );

  gff_stack #(
    .DEPTH (CELLS),
    .AW    (AW),
    .SW    (SW)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stack_ctl),
    .wdata (stack_wdata),
    .rdata (stack_rdata),
    .empty (stack_empty)
  );

endmodule

`default_nettype wire
